// File: sv/pbu_pkg.sv
// shared types, mode codes and register indexes of the pixel blend unit
package pbu_pkg;

  typedef enum logic [3:0] {
    MODE_MULTIPLY   = 4'd0,
    MODE_SUBTRACT   = 4'd1,
    MODE_SCREEN     = 4'd2,
    MODE_OVERLAY    = 4'd3,
    MODE_ADD        = 4'd4,
    MODE_SCALE      = 4'd5,
    MODE_GRAY_RED   = 4'd6,
    MODE_GRAY_GREEN = 4'd7,
    MODE_GRAY_BLUE  = 4'd8
  } mode_t;

  localparam int ADDR_W = 5;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_OFFSET_RED   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_OFFSET_GREEN = 3'd1;
  localparam logic [INDEX_W-1:0] REG_OFFSET_BLUE  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_GAIN_RED     = 3'd3;
  localparam logic [INDEX_W-1:0] REG_GAIN_GREEN   = 3'd4;
  localparam logic [INDEX_W-1:0] REG_GAIN_BLUE    = 3'd5;

  localparam logic signed [8:0]  OFFSET_RESET = 9'sd0;
  localparam logic signed [15:0] GAIN_RESET   = 16'sd256;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pixel_out_t;

endpackage

// File: sv/pbu_channel.sv
// blend logic for one color channel
module pbu_channel (
  input  logic [3:0]        mode,
  input  logic [7:0]        top,
  input  logic [7:0]        bottom,
  input  logic signed [8:0] offset,
  input  logic signed [15:0] gain,
  output logic [7:0]        value
);
  import pbu_pkg::*;

  // rounded divide by 255: estimate from shifts, then one correction step
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [16:0] y;
    logic [16:0] sum;
    logic [8:0]  est;
    logic [16:0] est_x255;
    logic [16:0] rem;
    y        = x + 17'd127;
    sum      = y + (y >> 8);
    est      = sum[16:8];
    est_x255 = {est, 8'd0} - {8'd0, est};
    rem      = y - est_x255;
    div255   = est + {8'd0, (rem >= 17'd255)};
  endfunction

  logic        invert_ops;
  logic        double_prod;
  logic [7:0]  op_a;
  logic [7:0]  op_b;
  logic [15:0] prod;
  logic [16:0] prod_x;
  logic [8:0]  quot;
  logic [7:0]  blend_out;

  logic [8:0]  diff;
  logic [7:0]  sub_out;

  logic signed [9:0] add_sum;
  logic [7:0]  add_out;

  logic signed [24:0] scaled;
  logic signed [24:0] rounded;
  logic [15:0] shifted;
  logic [7:0]  scale_out;

  // multiply, screen and both overlay halves share one product
  assign invert_ops  = (mode == MODE_SCREEN) || ((mode == MODE_OVERLAY) && bottom[7]);
  assign double_prod = (mode == MODE_OVERLAY);
  assign op_a        = invert_ops ? ~top : top;
  assign op_b        = invert_ops ? ~bottom : bottom;
  assign prod        = op_a * op_b;
  assign prod_x      = double_prod ? {prod, 1'b0} : {1'b0, prod};
  assign quot        = div255(prod_x);
  assign blend_out   = invert_ops ? ~quot[7:0] : quot[7:0];

  assign diff    = {1'b0, bottom} - {1'b0, top};
  assign sub_out = diff[8] ? 8'd0 : diff[7:0];

  assign add_sum = $signed({2'b00, top}) + $signed({offset[8], offset});
  always_comb begin
    if (add_sum[9]) begin
      add_out = 8'd0;
    end else if (add_sum[8]) begin
      add_out = 8'd255;
    end else begin
      add_out = add_sum[7:0];
    end
  end

  assign scaled  = $signed({1'b0, top}) * gain;
  assign rounded = scaled + 25'sd128;
  assign shifted = rounded[23:8];
  always_comb begin
    if (rounded[24]) begin
      scale_out = 8'd0;
    end else if (|shifted[15:8]) begin
      scale_out = 8'd255;
    end else begin
      scale_out = shifted[7:0];
    end
  end

  always_comb begin
    unique case (mode)
      MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY: value = blend_out;
      MODE_SUBTRACT: value = sub_out;
      MODE_ADD:      value = add_out;
      MODE_SCALE:    value = scale_out;
      default:       value = 8'd0;
    endcase
  end

endmodule

// File: sv/pixel_blend_unit.sv
// top level of the pixel blend unit: input register, channel blend, result register, apb registers
//
//  channel   signals                                   transfer
//  -------   ---------------------------------------   ---------------------------------
//  input     start, busy, pixel                        edge with start high and busy low
//  result    done, result                              edge that ends the done cycle
//  config    psel, penable, pwrite, paddr, pwdata,     edge with psel, penable, pwrite
//            prdata, pready                            and pready high
//
// one pixel per clock; the input register loads at the input transfer edge and the result
// register at the next edge, then the result transfers at the edge that ends the done cycle
// done is high for that one cycle
// busy is always low: the blend path is a single registered pass
// rst is synchronous: clears the valid flags and loads register reset values
// the receiver cannot stall, so no backpressure path exists
module pixel_blend_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pbu_pkg::pixel_in_t            pixel,
  output logic                          done,
  output pbu_pkg::pixel_out_t           result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbu_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pbu_pkg::*;

  // configuration registers
  logic signed [8:0]  offset_red;
  logic signed [8:0]  offset_green;
  logic signed [8:0]  offset_blue;
  logic signed [15:0] gain_red;
  logic signed [15:0] gain_green;
  logic signed [15:0] gain_blue;

  logic               cfg_write;
  logic [INDEX_W-1:0] cfg_index;

  // input register stage
  logic      in_valid;
  pixel_in_t pix;

  // channel outputs and next result
  logic [7:0] chan_red;
  logic [7:0] chan_green;
  logic [7:0] chan_blue;
  pixel_out_t result_next;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // apb access: register i sits at byte address 4*i
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_red   <= OFFSET_RESET;
      offset_green <= OFFSET_RESET;
      offset_blue  <= OFFSET_RESET;
      gain_red     <= GAIN_RESET;
      gain_green   <= GAIN_RESET;
      gain_blue    <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFFSET_RED:   offset_red   <= pwdata[8:0];
        REG_OFFSET_GREEN: offset_green <= pwdata[8:0];
        REG_OFFSET_BLUE:  offset_blue  <= pwdata[8:0];
        REG_GAIN_RED:     gain_red     <= pwdata[15:0];
        REG_GAIN_GREEN:   gain_green   <= pwdata[15:0];
        REG_GAIN_BLUE:    gain_blue    <= pwdata[15:0];
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // read back raw register bits, zero filled
  always_comb begin
    unique case (cfg_index)
      REG_OFFSET_RED:   prdata = {23'd0, offset_red};
      REG_OFFSET_GREEN: prdata = {23'd0, offset_green};
      REG_OFFSET_BLUE:  prdata = {23'd0, offset_blue};
      REG_GAIN_RED:     prdata = {16'd0, gain_red};
      REG_GAIN_GREEN:   prdata = {16'd0, gain_green};
      REG_GAIN_BLUE:    prdata = {16'd0, gain_blue};
      default:          prdata = 32'd0;
    endcase
  end

  // capture every input transfer; the payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pix <= pixel;
    end
  end

  // one blend slice per channel, each with its own offset and gain
  pbu_channel u_red (
    .mode   (pix.mode),
    .top    (pix.top_red),
    .bottom (pix.bottom_red),
    .offset (offset_red),
    .gain   (gain_red),
    .value  (chan_red)
  );

  pbu_channel u_green (
    .mode   (pix.mode),
    .top    (pix.top_green),
    .bottom (pix.bottom_green),
    .offset (offset_green),
    .gain   (gain_green),
    .value  (chan_green)
  );

  pbu_channel u_blue (
    .mode   (pix.mode),
    .top    (pix.top_blue),
    .bottom (pix.bottom_blue),
    .offset (offset_blue),
    .gain   (gain_blue),
    .value  (chan_blue)
  );

  // gray modes copy one top channel to all three outputs;
  // unused mode codes come out of the channel slices as zero
  always_comb begin
    unique case (pix.mode)
      MODE_GRAY_RED:   result_next = '{pix.top_red, pix.top_red, pix.top_red};
      MODE_GRAY_GREEN: result_next = '{pix.top_green, pix.top_green, pix.top_green};
      MODE_GRAY_BLUE:  result_next = '{pix.top_blue, pix.top_blue, pix.top_blue};
      default:         result_next = '{chan_red, chan_green, chan_blue};
    endcase
  end

  // result register: done marks the single cycle the result is valid
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= result_next;
    end
  end

endmodule
